/* rtl/bpdmc_pkg.sv */
// types, constants and rounding helper shared by the balance pd mode controller
package bpdmc_pkg;

    // output range, 24-bit signed
    localparam logic signed [23:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [23:0] OUT_MIN = -24'sd8388608;

    // configuration register indexes
    localparam logic [1:0] CFG_PITCH_LIMIT      = 2'd0;
    localparam logic [1:0] CFG_ROLL_LIMIT       = 2'd1;
    localparam logic [1:0] CFG_SMALL_ROLL_LIMIT = 2'd2;

    // configuration reset values, Q5.10 radians
    localparam logic [14:0] PITCH_LIMIT_RST      = 15'd1608;
    localparam logic [14:0] ROLL_LIMIT_RST       = 15'd1434;
    localparam logic [14:0] SMALL_ROLL_LIMIT_RST = 15'd51;

    // roll sign codes, two's complement
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    // control gains
    localparam logic signed [23:0] WHEEL_KP  = 24'sd15;
    localparam logic signed [23:0] SMALL_KP  = 24'sd15;
    localparam logic signed [23:0] SMALL_KD  = 24'sd3;
    localparam logic signed [23:0] DASH_KP   = 24'sd35;
    localparam logic signed [23:0] DASH_KD   = 24'sd5;
    localparam logic signed [23:0] DISC_BIAS = 24'sd102;

    // rounded division by reciprocal multiply: half, multiplier, shift
    localparam logic [6:0]  DIV20_HALF   = 7'd10;
    localparam logic [16:0] DIV20_MULT   = 17'd104858;
    localparam logic [4:0]  DIV20_SHIFT  = 5'd21;
    localparam logic [6:0]  DIV100_HALF  = 7'd50;
    localparam logic [16:0] DIV100_MULT  = 17'd83887;
    localparam logic [4:0]  DIV100_SHIFT = 5'd23;
    localparam logic [6:0]  DIV200_HALF  = 7'd100;
    localparam logic [16:0] DIV200_MULT  = 17'd83887;
    localparam logic [4:0]  DIV200_SHIFT = 5'd24;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_rate;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] wheel_velocity;
        logic signed [15:0] disc_velocity;
    } bpdmc_in_t;

    typedef struct packed {
        logic signed [23:0] wheel_command;
        logic signed [23:0] disc_command;
        logic               fallen;
        logic               dash_active;
        logic signed [23:0] integrated_roll;
    } bpdmc_out_t;

    typedef struct packed {
        logic [14:0] pitch_limit;
        logic [14:0] roll_limit;
        logic [14:0] small_roll_limit;
    } bpdmc_cfg_t;

    typedef struct packed {
        logic               dash_mode;
        logic signed [1:0]  prev_sign;
        logic signed [23:0] held_disc;
        logic signed [23:0] roll_integral;
    } bpdmc_state_t;

    // round(num / d), ties away from zero; mult = ceil(2^shift / d)
    function automatic logic signed [23:0] round_div(
        input logic signed [15:0] num,
        input logic [6:0]         half,
        input logic [16:0]        mult,
        input logic [4:0]         shift
    );
        logic signed [16:0] wide;
        logic [16:0]        mag;
        logic [33:0]        prod;
        logic [23:0]        q;
        wide = 17'(num);
        mag  = wide[16] ? 17'(-wide) : 17'(wide);
        mag  = mag + 17'(half);
        prod = 34'(mag) * 34'(mult);
        q    = 24'(prod >> shift);
        return num[15] ? -$signed(q) : $signed(q);
    endfunction

endpackage

/* rtl/balance_pd_mode_controller_top.sv */
// Balance PD mode controller: sensor sample in, wheel and disc commands out.
//
// Channels: s_valid/s_ready/s_data carries one sensor sample per beat (Q5.10
// angles, rates and joint velocities). m_valid/m_ready/m_data returns exactly
// one result beat per sample, in order: wheel and disc commands, fall flag,
// dash-mode flag and the roll-rate integral.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data writes pitch_limit (0),
// roll_limit (1) and small_roll_limit (2); other indexes are ignored. cfg_ready
// is always high; write only while no sample is in flight.
// Path: an accepted sample sits in the input register; its result is loaded into
// the output register once that register is free, and m_valid then rises.
// Throughput: one sample per cycle while the output is free; the laws, the
// mode update and the reciprocal-multiply rounding all sit in one combinational
// pass between the input and output registers, and the mode state updates as
// each result loads.
// Reset: aresetn low clears both stages, the mode state, the held disc command
// and the integral, and restores the default limits.
// Stall: while m_ready is low the result holds; one more sample is taken into
// the input register, after which s_ready drops until the result is taken.
module balance_pd_mode_controller_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bpdmc_pkg::bpdmc_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bpdmc_pkg::bpdmc_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [14:0]           cfg_data
);
    import bpdmc_pkg::*;

    logic         in_valid_reg;
    bpdmc_in_t    in_item_reg;
    logic         out_valid_reg;
    bpdmc_out_t   out_item_reg;
    bpdmc_state_t state_reg;
    bpdmc_state_t state_next;
    bpdmc_cfg_t   cfg_reg;
    bpdmc_out_t   result_next;
    logic         advance;

    // handshake: input stage moves on when the output register is free
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_limit      <= PITCH_LIMIT_RST;
            cfg_reg.roll_limit       <= ROLL_LIMIT_RST;
            cfg_reg.small_roll_limit <= SMALL_ROLL_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PITCH_LIMIT:      cfg_reg.pitch_limit      <= cfg_data;
                CFG_ROLL_LIMIT:       cfg_reg.roll_limit       <= cfg_data;
                CFG_SMALL_ROLL_LIMIT: cfg_reg.small_roll_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // laws and mode update
    bpdmc_laws u_laws (
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // controller state, updated as each result is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.dash_mode     <= 1'b0;
            state_reg.prev_sign     <= SIGN_ZERO;
            state_reg.held_disc     <= 24'sd0;
            state_reg.roll_integral <= 24'sd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

`ifndef NO_ASSERTIONS
    // mode state only moves when a sample is processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("controller state changed without a sample");

    // a taken result with nothing behind it leaves the output empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !in_valid_reg |=> !m_valid)
        else $error("result beat repeated");

    // a fallen sample keeps the dash mode as it was
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result_next.fallen |=> state_reg.dash_mode == $past(state_reg.dash_mode))
        else $error("dash mode changed while fallen");

    // input side only stalls behind a stalled full output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");
`endif

endmodule

/* rtl/bpdmc_laws.sv */
// control laws, fall detection and mode update for one sensor sample
module bpdmc_laws (
    input  bpdmc_pkg::bpdmc_in_t    item,
    input  bpdmc_pkg::bpdmc_cfg_t   cfg,
    input  bpdmc_pkg::bpdmc_state_t state,
    output bpdmc_pkg::bpdmc_state_t state_next,
    output bpdmc_pkg::bpdmc_out_t   result
);
    import bpdmc_pkg::*;

    logic signed [16:0] r_wide;
    logic signed [16:0] p_wide;
    logic [16:0]        r_abs;
    logic [16:0]        p_abs;
    logic signed [1:0]  sgn;
    logic               fallen;
    logic signed [23:0] wheel_stand;
    logic signed [23:0] wheel_brake;
    logic signed [23:0] disc_small;
    logic signed [23:0] disc_dash;
    logic signed [23:0] disc_brake;
    logic signed [23:0] bias;
    logic signed [23:0] integ_step;
    logic signed [24:0] integ_sum;
    logic signed [23:0] integ_sat;

    // magnitudes and roll sign
    assign r_wide = 17'(item.roll_angle);
    assign p_wide = 17'(item.pitch_angle);
    assign r_abs  = r_wide[16] ? 17'(-r_wide) : 17'(r_wide);
    assign p_abs  = p_wide[16] ? 17'(-p_wide) : 17'(p_wide);

    always_comb begin
        if (item.roll_angle > 16'sd0) begin
            sgn = SIGN_POS;
        end else if (item.roll_angle < 16'sd0) begin
            sgn = SIGN_NEG;
        end else begin
            sgn = SIGN_ZERO;
        end
    end

    // fall detection
    assign fallen = (p_abs >= {2'b00, cfg.pitch_limit}) ||
                    (r_abs >= {2'b00, cfg.roll_limit});

    // wheel laws
    assign wheel_stand = -(24'(item.pitch_angle) * WHEEL_KP) - 24'(item.pitch_rate);
    assign wheel_brake = -round_div(item.wheel_velocity, DIV20_HALF, DIV20_MULT,
                                    DIV20_SHIFT);

    // disc laws
    always_comb begin
        case (sgn)
            SIGN_POS: bias = DISC_BIAS;
            SIGN_NEG: bias = -DISC_BIAS;
            default:  bias = 24'sd0;
        endcase
    end

    assign disc_small = 24'(item.roll_angle) * SMALL_KP + 24'(item.roll_rate) * SMALL_KD + bias;
    assign disc_dash  = 24'(item.roll_angle) * DASH_KP + 24'(item.roll_rate) * DASH_KD;
    assign disc_brake = -round_div(item.disc_velocity, DIV100_HALF, DIV100_MULT,
                                   DIV100_SHIFT);

    // saturating roll-rate integrator
    assign integ_step = round_div(item.roll_rate, DIV200_HALF, DIV200_MULT, DIV200_SHIFT);
    assign integ_sum  = 25'(state.roll_integral) + 25'(integ_step);

    always_comb begin
        if (integ_sum > 25'(OUT_MAX)) begin
            integ_sat = OUT_MAX;
        end else if (integ_sum < 25'(OUT_MIN)) begin
            integ_sat = OUT_MIN;
        end else begin
            integ_sat = integ_sum[23:0];
        end
    end

    // mode update and held disc command
    always_comb begin
        state_next               = state;
        state_next.prev_sign     = sgn;
        state_next.roll_integral = integ_sat;
        if (fallen) begin
            state_next.held_disc = disc_brake;
        end else if (!state.dash_mode) begin
            if (r_abs < {2'b00, cfg.small_roll_limit}) begin
                state_next.held_disc = disc_small;
            end else begin
                state_next.dash_mode = 1'b1;
            end
        end else begin
            if (sgn == state.prev_sign) begin
                state_next.held_disc = disc_dash;
            end else begin
                state_next.dash_mode = 1'b0;
            end
        end
    end

    // result beat
    always_comb begin
        result.wheel_command   = fallen ? wheel_brake : wheel_stand;
        result.disc_command    = state_next.held_disc;
        result.fallen          = fallen;
        result.dash_active     = state_next.dash_mode;
        result.integrated_roll = state_next.roll_integral;
    end

endmodule
